### src/scmhp_pkg.sv
// ----------------------------------------------------------------------------
// SigComp header parser package
// Shared types, phase codes, byte roles, status codes and a lookup function.
// ----------------------------------------------------------------------------
package scmhp_pkg;

	localparam logic [15:0] MAX_MESSAGE_BYTES = 16'd65535;
	localparam logic [11:0] NACK_MIN_BYTES    = 12'd26;

	typedef enum logic [3:0] {
		PH_HEAD,
		PH_FB_FIRST,
		PH_FB_REST,
		PH_SID,
		PH_CODE0,
		PH_CODE1,
		PH_BYTECODE,
		PH_NACK,
		PH_REMAIN,
		PH_DISCARD
	} phase_t;

	localparam logic [3:0] ROLE_HEADER     = 4'd0;
	localparam logic [3:0] ROLE_FEEDBACK   = 4'd1;
	localparam logic [3:0] ROLE_STATE_ID   = 4'd2;
	localparam logic [3:0] ROLE_CODE_LEN   = 4'd3;
	localparam logic [3:0] ROLE_BYTECODE   = 4'd4;
	localparam logic [3:0] ROLE_REMAINING  = 4'd5;
	localparam logic [3:0] ROLE_NACK_FIELD = 4'd6;
	localparam logic [3:0] ROLE_HASH       = 4'd7;
	localparam logic [3:0] ROLE_DETAILS    = 4'd8;
	localparam logic [3:0] ROLE_DISCARD    = 4'd9;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
	localparam logic [2:0] ST_BAD_CODELOC = 3'd3;
	localparam logic [2:0] ST_BAD_VERSION = 3'd4;

	localparam logic [1:0] KIND_STATEFUL  = 2'd0;
	localparam logic [1:0] KIND_STATELESS = 2'd1;
	localparam logic [1:0] KIND_NACK      = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [3:0]  byte_role;
		logic        message_done;
		logic [2:0]  status;
		logic [1:0]  message_kind;
		logic [10:0] code_destination;
		logic [11:0] bytecode_length;
		logic [3:0]  state_id_length;
		logic [15:0] head_bytes;
		logic [7:0]  nack_reason;
		logic [7:0]  nack_opcode;
		logic [15:0] nack_pc;
	} result_item_t;

	function automatic logic [3:0] sid_len(input logic [1:0] code);
		logic [3:0] n;
		unique case (code)
			2'd0: n = 4'd0;
			2'd1: n = 4'd6;
			2'd2: n = 4'd9;
			default: n = 4'd12;
		endcase
		return n;
	endfunction

endpackage

### src/scmhp_step.sv
// ----------------------------------------------------------------------------
// SigComp header parser step
// Per-message state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module scmhp_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  scmhp_pkg::byte_item_t item,
	output scmhp_pkg::result_item_t result
);

	scmhp_pkg::phase_t phase_q, n_phase;
	logic [11:0] count_q, n_count;
	logic [15:0] total_q, n_total;
	logic [1:0]  hdr_q, n_hdr;
	logic [7:0]  fcb_q, n_fcb;
	logic [11:0] len_q, n_len;
	logic [10:0] dest_q, n_dest;
	logic [2:0]  err_q, n_err;
	logic [1:0]  kind_q, n_kind;
	logic [15:0] hbytes_q, n_hbytes;
	logic [31:0] nack_q, n_nack;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= scmhp_pkg::PH_HEAD;
			count_q  <= '0;
			total_q  <= '0;
			hdr_q    <= '0;
			fcb_q    <= '0;
			len_q    <= '0;
			dest_q   <= '0;
			err_q    <= '0;
			kind_q   <= '0;
			hbytes_q <= '0;
			nack_q   <= '0;
		end else if (advance) begin
			phase_q  <= n_phase;
			count_q  <= n_count;
			total_q  <= n_total;
			hdr_q    <= n_hdr;
			fcb_q    <= n_fcb;
			len_q    <= n_len;
			dest_q   <= n_dest;
			err_q    <= n_err;
			kind_q   <= n_kind;
			hbytes_q <= n_hbytes;
			nack_q   <= n_nack;
		end
	end

	always_comb begin
		logic [7:0]  b;
		logic [3:0]  role;
		logic [2:0]  status;
		logic [3:0]  sid_b;
		logic [3:0]  sid_h;
		logic [4:0]  dsum;
		logic [11:0] cnt_dec;

		b       = item.data_byte;
		role    = scmhp_pkg::ROLE_DISCARD;
		status  = scmhp_pkg::ST_OK;
		sid_b   = scmhp_pkg::sid_len(b[1:0]);
		sid_h   = scmhp_pkg::sid_len(hdr_q);
		dsum    = {1'b0, b[3:0]} + 5'd1;
		cnt_dec = count_q - 12'd1;

		n_phase  = phase_q;
		n_count  = count_q;
		n_total  = (total_q < scmhp_pkg::MAX_MESSAGE_BYTES) ? total_q + 16'd1 : total_q;
		n_hdr    = hdr_q;
		n_fcb    = fcb_q;
		n_len    = len_q;
		n_dest   = dest_q;
		n_err    = err_q;
		n_kind   = kind_q;
		n_hbytes = hbytes_q;
		n_nack   = nack_q;

		unique case (phase_q)
			scmhp_pkg::PH_HEAD: begin
				role  = scmhp_pkg::ROLE_HEADER;
				n_hdr = b[1:0];
				if (b < 8'hf8) begin
					n_err   = scmhp_pkg::ST_BAD_MAGIC;
					n_phase = scmhp_pkg::PH_DISCARD;
				end else if (b[2]) begin
					n_phase = scmhp_pkg::PH_FB_FIRST;
				end else if (sid_b != 4'd0) begin
					n_kind  = scmhp_pkg::KIND_STATEFUL;
					n_phase = scmhp_pkg::PH_SID;
					n_count = {8'd0, sid_b};
				end else begin
					n_phase = scmhp_pkg::PH_CODE0;
				end
			end
			scmhp_pkg::PH_FB_FIRST, scmhp_pkg::PH_FB_REST: begin
				role = scmhp_pkg::ROLE_FEEDBACK;
				if (phase_q == scmhp_pkg::PH_FB_FIRST && b > 8'd128) begin
					n_count = {5'd0, b[6:0]};
					n_phase = scmhp_pkg::PH_FB_REST;
				end else begin
					if (phase_q == scmhp_pkg::PH_FB_REST)
						n_count = cnt_dec;
					if (phase_q == scmhp_pkg::PH_FB_FIRST || cnt_dec == 12'd0) begin
						if (sid_h != 4'd0) begin
							n_kind  = scmhp_pkg::KIND_STATEFUL;
							n_phase = scmhp_pkg::PH_SID;
							n_count = {8'd0, sid_h};
						end else begin
							n_phase = scmhp_pkg::PH_CODE0;
						end
					end
				end
			end
			scmhp_pkg::PH_SID, scmhp_pkg::PH_BYTECODE: begin
				role    = (phase_q == scmhp_pkg::PH_SID) ? scmhp_pkg::ROLE_STATE_ID
				                                         : scmhp_pkg::ROLE_BYTECODE;
				n_count = cnt_dec;
				if (cnt_dec == 12'd0) begin
					n_hbytes = n_total;
					n_phase  = scmhp_pkg::PH_REMAIN;
				end
			end
			scmhp_pkg::PH_CODE0: begin
				role    = scmhp_pkg::ROLE_CODE_LEN;
				n_fcb   = b;
				n_phase = scmhp_pkg::PH_CODE1;
			end
			scmhp_pkg::PH_CODE1: begin
				if (fcb_q == 8'd0 && b[7:4] == 4'd0) begin
					role    = scmhp_pkg::ROLE_NACK_FIELD;
					n_kind  = scmhp_pkg::KIND_NACK;
					n_phase = scmhp_pkg::PH_NACK;
					n_count = 12'd2;
					if (b != 8'd1)
						n_err = scmhp_pkg::ST_BAD_VERSION;
				end else begin
					role   = scmhp_pkg::ROLE_CODE_LEN;
					n_kind = scmhp_pkg::KIND_STATELESS;
					n_dest = {dsum, 6'd0};
					n_len  = {fcb_q, b[7:4]};
					if (n_dest < 11'd128 || n_dest > 11'd1024) begin
						n_err   = scmhp_pkg::ST_BAD_CODELOC;
						n_phase = scmhp_pkg::PH_DISCARD;
					end else begin
						n_count = {fcb_q, b[7:4]};
						n_phase = scmhp_pkg::PH_BYTECODE;
					end
				end
			end
			scmhp_pkg::PH_NACK: begin
				priority if (count_q == 12'd2) begin
					role          = scmhp_pkg::ROLE_NACK_FIELD;
					n_nack[31:24] = b;
				end else if (count_q == 12'd3) begin
					role          = scmhp_pkg::ROLE_NACK_FIELD;
					n_nack[23:16] = b;
				end else if (count_q == 12'd4) begin
					role          = scmhp_pkg::ROLE_NACK_FIELD;
					n_nack[15:8]  = b;
				end else if (count_q == 12'd5) begin
					role          = scmhp_pkg::ROLE_NACK_FIELD;
					n_nack[7:0]   = b;
				end else if (count_q < scmhp_pkg::NACK_MIN_BYTES) begin
					role = scmhp_pkg::ROLE_HASH;
				end else begin
					role = scmhp_pkg::ROLE_DETAILS;
				end
				if (err_q != scmhp_pkg::ST_OK)
					role = scmhp_pkg::ROLE_DISCARD;
				if (count_q < scmhp_pkg::NACK_MIN_BYTES)
					n_count = count_q + 12'd1;
			end
			scmhp_pkg::PH_REMAIN: role = scmhp_pkg::ROLE_REMAINING;
			default: role = scmhp_pkg::ROLE_DISCARD;
		endcase

		result           = '0;
		result.byte_out  = b;
		result.byte_role = role;

		if (item.last_byte) begin
			priority if (n_total < 16'd2)
				status = scmhp_pkg::ST_TOO_SHORT;
			else if (n_phase == scmhp_pkg::PH_DISCARD)
				status = n_err;
			else if (n_phase == scmhp_pkg::PH_REMAIN)
				status = scmhp_pkg::ST_OK;
			else if (n_phase == scmhp_pkg::PH_NACK)
				status = (n_count < scmhp_pkg::NACK_MIN_BYTES) ? scmhp_pkg::ST_TOO_SHORT
				                                               : n_err;
			else
				status = scmhp_pkg::ST_TOO_SHORT;

			result.message_done = 1'b1;
			result.status       = status;
			if (status == scmhp_pkg::ST_OK) begin
				result.message_kind = n_kind;
				unique case (n_kind)
					scmhp_pkg::KIND_STATEFUL: begin
						result.state_id_length = scmhp_pkg::sid_len(n_hdr);
						result.head_bytes      = n_hbytes;
					end
					scmhp_pkg::KIND_STATELESS: begin
						result.code_destination = n_dest;
						result.bytecode_length  = n_len;
						result.head_bytes       = n_hbytes;
					end
					default: begin
						result.head_bytes  = n_total;
						result.nack_reason = n_nack[31:24];
						result.nack_opcode = n_nack[23:16];
						result.nack_pc     = n_nack[15:0];
					end
				endcase
			end

			n_phase  = scmhp_pkg::PH_HEAD;
			n_count  = '0;
			n_total  = '0;
			n_hdr    = '0;
			n_fcb    = '0;
			n_len    = '0;
			n_dest   = '0;
			n_err    = '0;
			n_kind   = '0;
			n_hbytes = '0;
			n_nack   = '0;
		end
	end

endmodule

### src/sigcomp_message_header_parser.sv
// Each accepted byte is held in the input register; its result is registered in the result register.
// Throughput: one byte per cycle while the result is not stalled; the per-message state updates on each advance.
// Reset: arst_n clears both stage valids and the parser state; the parser then
// expects the header byte of a new message.
// ----------------------------------------------------------------------------
// SigComp message header parser
// Input register, per-byte parse step and result register with stall handling.
// ----------------------------------------------------------------------------
module sigcomp_message_header_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  scmhp_pkg::byte_item_t   byte_item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output scmhp_pkg::result_item_t result_item
);

	logic                    valid_s1;
	scmhp_pkg::byte_item_t   item_s1;
	logic                    result_valid_q;
	scmhp_pkg::result_item_t result_q;
	scmhp_pkg::result_item_t step_result;
	logic                    advance;
	logic                    accept;

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= byte_item;
	end

	scmhp_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= step_result;
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

endmodule

### src/scmhp_checker.sv
// ----------------------------------------------------------------------------
// SigComp header parser checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module scmhp_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    byte_valid,
	input logic                    byte_stall,
	input scmhp_pkg::byte_item_t   byte_item,
	input logic                    result_valid,
	input logic                    result_stall,
	input scmhp_pkg::result_item_t result_item
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("stalled result changed");

	a_mid_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.message_done |->
			result_item.status == scmhp_pkg::ST_OK &&
			result_item.message_kind == scmhp_pkg::KIND_STATEFUL &&
			result_item.head_bytes == 16'd0 && result_item.nack_pc == 16'd0)
		else $error("summary fields set before last transfer");

	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.status != scmhp_pkg::ST_OK |->
			result_item.message_kind == scmhp_pkg::KIND_STATEFUL &&
			result_item.head_bytes == 16'd0 && result_item.code_destination == 11'd0)
		else $error("fields set on failed message");

	a_dest_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.message_done &&
		result_item.status == scmhp_pkg::ST_OK &&
		result_item.message_kind == scmhp_pkg::KIND_STATELESS |->
			result_item.code_destination >= 11'd128 &&
			result_item.code_destination <= 11'd1024)
		else $error("code destination out of range");

	a_nack_size: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.message_done &&
		result_item.status == scmhp_pkg::ST_OK &&
		result_item.message_kind == scmhp_pkg::KIND_NACK |->
			result_item.head_bytes >= 16'd26)
		else $error("short NACK reported ok");

endmodule

bind sigcomp_message_header_parser scmhp_checker u_scmhp_checker (.*);

### bench/scmhp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SigComp header parser result checker
// Watches the byte and result channels and predicts the role tag and final
// header fields of every accepted byte. Each result transfer is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module scmhp_result_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	input  logic                    byte_stall,
	input  scmhp_pkg::byte_item_t   byte_item,
	input  logic                    result_valid,
	input  logic                    result_stall,
	input  scmhp_pkg::result_item_t result_item,
	output int                      mismatches,
	output int                      outstanding,
	output int                      msgs_ok,
	output int                      msgs_bad
);

	scmhp_pkg::phase_t       parse_phase;
	logic [11:0]             step_count;
	logic [15:0]             msg_bytes;
	logic [7:0]              hdr_byte;
	logic [7:0]              code_hi;
	logic [11:0]             bc_length;
	logic [10:0]             load_addr;
	logic [2:0]              err_code;
	logic [1:0]              msg_kind;
	logic [15:0]             hdr_size;
	logic [7:0]              nack_reason;
	logic [7:0]              nack_opcode;
	logic [15:0]             nack_pc;
	scmhp_pkg::result_item_t predicted_bytes[$];
	scmhp_pkg::result_item_t want;
	int                      results_seen;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int exp_val);
		if (got != exp_val) begin
			report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
				results_seen, name, got, exp_val));
		end
	endtask

	function automatic logic [3:0] id_bytes(input logic [1:0] code);
		case (code)
			2'd0: return 4'd0;
			2'd1: return 4'd6;
			2'd2: return 4'd9;
			default: return 4'd12;
		endcase
	endfunction

	function automatic void clear_state();
		parse_phase = scmhp_pkg::PH_HEAD;
		step_count  = '0;
		msg_bytes   = '0;
		hdr_byte    = '0;
		code_hi     = '0;
		bc_length   = '0;
		load_addr   = '0;
		err_code    = scmhp_pkg::ST_OK;
		msg_kind    = scmhp_pkg::KIND_STATEFUL;
		hdr_size    = '0;
		nack_reason = '0;
		nack_opcode = '0;
		nack_pc     = '0;
	endfunction

	// state id follows when the header's length code is nonzero, else the code length bytes
	function automatic void enter_body();
		if (id_bytes(hdr_byte[1:0]) != 4'd0) begin
			msg_kind    = scmhp_pkg::KIND_STATEFUL;
			parse_phase = scmhp_pkg::PH_SID;
			step_count  = {8'd0, id_bytes(hdr_byte[1:0])};
		end else begin
			parse_phase = scmhp_pkg::PH_CODE0;
		end
	endfunction

	function automatic scmhp_pkg::result_item_t parse_byte(input scmhp_pkg::byte_item_t item);
		scmhp_pkg::result_item_t r;
		logic [7:0]              b;
		logic [2:0]              st;
		b = item.data_byte;
		r = '0;
		r.byte_out = b;
		r.byte_role = scmhp_pkg::ROLE_DISCARD;
		st = scmhp_pkg::ST_OK;
		if (msg_bytes != scmhp_pkg::MAX_MESSAGE_BYTES)
			msg_bytes = msg_bytes + 16'd1;
		case (parse_phase)
			scmhp_pkg::PH_HEAD: begin
				r.byte_role = scmhp_pkg::ROLE_HEADER;
				hdr_byte = b;
				if (b < 8'hf8) begin
					err_code = scmhp_pkg::ST_BAD_MAGIC;
					parse_phase = scmhp_pkg::PH_DISCARD;
				end else if (b[2]) begin
					parse_phase = scmhp_pkg::PH_FB_FIRST;
				end else begin
					enter_body();
				end
			end
			scmhp_pkg::PH_FB_FIRST: begin
				r.byte_role = scmhp_pkg::ROLE_FEEDBACK;
				if (b <= 8'd128) begin
					enter_body();
				end else begin
					step_count = {5'd0, b[6:0]};
					parse_phase = scmhp_pkg::PH_FB_REST;
				end
			end
			scmhp_pkg::PH_FB_REST: begin
				r.byte_role = scmhp_pkg::ROLE_FEEDBACK;
				step_count = step_count - 12'd1;
				if (step_count == 12'd0)
					enter_body();
			end
			scmhp_pkg::PH_SID: begin
				r.byte_role = scmhp_pkg::ROLE_STATE_ID;
				step_count = step_count - 12'd1;
				if (step_count == 12'd0) begin
					hdr_size = msg_bytes;
					parse_phase = scmhp_pkg::PH_REMAIN;
				end
			end
			scmhp_pkg::PH_CODE0: begin
				r.byte_role = scmhp_pkg::ROLE_CODE_LEN;
				code_hi = b;
				parse_phase = scmhp_pkg::PH_CODE1;
			end
			scmhp_pkg::PH_CODE1: begin
				if (code_hi == 8'd0 && b[7:4] == 4'd0) begin
					r.byte_role = scmhp_pkg::ROLE_NACK_FIELD;
					msg_kind = scmhp_pkg::KIND_NACK;
					parse_phase = scmhp_pkg::PH_NACK;
					step_count = 12'd2;
					if (b != 8'd1)
						err_code = scmhp_pkg::ST_BAD_VERSION;
				end else begin
					r.byte_role = scmhp_pkg::ROLE_CODE_LEN;
					msg_kind = scmhp_pkg::KIND_STATELESS;
					load_addr = ({7'd0, b[3:0]} + 11'd1) << 6;
					bc_length = {code_hi, b[7:4]};
					if (load_addr < 11'd128 || load_addr > 11'd1024) begin
						err_code = scmhp_pkg::ST_BAD_CODELOC;
						parse_phase = scmhp_pkg::PH_DISCARD;
					end else begin
						step_count = bc_length;
						parse_phase = scmhp_pkg::PH_BYTECODE;
					end
				end
			end
			scmhp_pkg::PH_BYTECODE: begin
				r.byte_role = scmhp_pkg::ROLE_BYTECODE;
				step_count = step_count - 12'd1;
				if (step_count == 12'd0) begin
					hdr_size = msg_bytes;
					parse_phase = scmhp_pkg::PH_REMAIN;
				end
			end
			scmhp_pkg::PH_NACK: begin
				case (step_count)
					12'd2: nack_reason = b;
					12'd3: nack_opcode = b;
					12'd4: nack_pc[15:8] = b;
					12'd5: nack_pc[7:0] = b;
					default: ;
				endcase
				if (step_count <= 12'd5)
					r.byte_role = scmhp_pkg::ROLE_NACK_FIELD;
				else if (step_count < scmhp_pkg::NACK_MIN_BYTES)
					r.byte_role = scmhp_pkg::ROLE_HASH;
				else
					r.byte_role = scmhp_pkg::ROLE_DETAILS;
				if (err_code != scmhp_pkg::ST_OK)
					r.byte_role = scmhp_pkg::ROLE_DISCARD;
				if (step_count < scmhp_pkg::NACK_MIN_BYTES)
					step_count = step_count + 12'd1;
			end
			scmhp_pkg::PH_REMAIN: r.byte_role = scmhp_pkg::ROLE_REMAINING;
			default: r.byte_role = scmhp_pkg::ROLE_DISCARD;
		endcase

		if (item.last_byte) begin
			if (msg_bytes < 16'd2)
				st = scmhp_pkg::ST_TOO_SHORT;
			else if (parse_phase == scmhp_pkg::PH_DISCARD)
				st = err_code;
			else if (parse_phase == scmhp_pkg::PH_REMAIN)
				st = scmhp_pkg::ST_OK;
			else if (parse_phase == scmhp_pkg::PH_NACK)
				st = (step_count < scmhp_pkg::NACK_MIN_BYTES) ? scmhp_pkg::ST_TOO_SHORT
				                                               : err_code;
			else
				st = scmhp_pkg::ST_TOO_SHORT;
			r.message_done = 1'b1;
			r.status = st;
			if (st == scmhp_pkg::ST_OK) begin
				r.message_kind = msg_kind;
				case (msg_kind)
					scmhp_pkg::KIND_STATEFUL: begin
						r.state_id_length = id_bytes(hdr_byte[1:0]);
						r.head_bytes = hdr_size;
					end
					scmhp_pkg::KIND_STATELESS: begin
						r.code_destination = load_addr;
						r.bytecode_length = bc_length;
						r.head_bytes = hdr_size;
					end
					default: begin
						r.head_bytes = msg_bytes;
						r.nack_reason = nack_reason;
						r.nack_opcode = nack_opcode;
						r.nack_pc = nack_pc;
					end
				endcase
			end
			clear_state();
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_state();
			predicted_bytes.delete();
		end else begin
			if (byte_valid && !byte_stall) begin
				want = parse_byte(byte_item);
				predicted_bytes.push_back(want);
				if (want.message_done) begin
					if (want.status == scmhp_pkg::ST_OK)
						msgs_ok++;
					else
						msgs_bad++;
				end
			end
			if (result_valid && !result_stall) begin
				results_seen++;
				if (predicted_bytes.size() == 0) begin
					report_mismatch($sformatf("result %0d with no byte outstanding, byte_out %0d",
						results_seen, result_item.byte_out));
				end else begin
					want = predicted_bytes.pop_front();
					check_field("byte_out", result_item.byte_out, want.byte_out);
					check_field("byte_role", result_item.byte_role, want.byte_role);
					check_field("message_done", result_item.message_done, want.message_done);
					check_field("status", result_item.status, want.status);
					check_field("message_kind", result_item.message_kind, want.message_kind);
					check_field("code_destination", result_item.code_destination,
						want.code_destination);
					check_field("bytecode_length", result_item.bytecode_length,
						want.bytecode_length);
					check_field("state_id_length", result_item.state_id_length,
						want.state_id_length);
					check_field("head_bytes", result_item.head_bytes, want.head_bytes);
					check_field("nack_reason", result_item.nack_reason, want.nack_reason);
					check_field("nack_opcode", result_item.nack_opcode, want.nack_opcode);
					check_field("nack_pc", result_item.nack_pc, want.nack_pc);
				end
			end
		end
		outstanding = predicted_bytes.size();
	end

endmodule

### bench/sigcomp_message_header_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SigComp header parser testbench
// Streams directed and random SigComp messages (stateful, stateless, NACK,
// bad magic, bad code location, cut short and noise) into the parser with
// random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module sigcomp_message_header_parser_test;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    byte_valid;
	logic                    byte_stall;
	scmhp_pkg::byte_item_t   byte_item;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	scmhp_pkg::result_item_t result_item;
	int                      mismatches;
	int                      outstanding;
	int                      msgs_ok;
	int                      msgs_bad;

	logic [7:0]   msg[$];
	int           idle_pct;
	int           stall_pct;
	int           stall_left;
	int           bytes_sent;

	sigcomp_message_header_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	scmhp_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.msgs_ok      (msgs_ok),
		.msgs_bad     (msgs_bad)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
			stall_left = $urandom_range(1, 9);
		result_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left = stall_left - 1;
	end

	initial begin
		#100_000_000;
		$display("timeout with %0d results outstanding", outstanding);
		$display("sigcomp_message_header_parser_test NOT OK");
		$finish;
	end

	task automatic put_rand(input int n);
		repeat (n) msg.push_back(8'($urandom));
	endtask

	// fb_len: negative for no feedback, 0 for a one-byte item, else long item size
	task automatic put_head(input logic [1:0] id_code, input int fb_len);
		msg.push_back({5'b11111, fb_len >= 0, id_code});
		if (fb_len == 0) begin
			msg.push_back(8'($urandom_range(0, 128)));
		end else if (fb_len > 0) begin
			msg.push_back(8'(8'h80 | fb_len));
			put_rand(fb_len);
		end
	endtask

	task automatic build_stateful(input logic [1:0] id_code, input int fb_len, input int rem);
		put_head(id_code, fb_len);
		put_rand(id_code == 2'd1 ? 6 : id_code == 2'd2 ? 9 : 12);
		put_rand(rem);
	endtask

	task automatic build_stateless(input int fb_len, input logic [11:0] len,
		input logic [3:0] dest_code, input int rem);
		put_head(2'd0, fb_len);
		msg.push_back(len[11:4]);
		msg.push_back({len[3:0], dest_code});
		put_rand(int'(len));
		put_rand(rem);
	endtask

	task automatic build_nack(input int fb_len, input logic [3:0] version, input int details);
		put_head(2'd0, fb_len);
		msg.push_back(8'h00);
		msg.push_back({4'h0, version});
		put_rand(24 + details);
	endtask

	task automatic cut_to(input int n);
		while (msg.size() > n)
			void'(msg.pop_back());
	endtask

	// leave valid high on exit; the next byte or an explicit drop follows
	task automatic send_msg();
		int k;
		for (k = 0; k < msg.size(); k++) begin
			if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				byte_valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			byte_valid <= 1'b1;
			byte_item <= {msg[k], (k == msg.size() - 1) ? 1'b1 : 1'b0};
			@(posedge clk);
			while (byte_stall)
				@(posedge clk);
			@(negedge clk);
			bytes_sent++;
		end
		msg.delete();
	endtask

	initial begin
		int pick;
		int fb;
		int w;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_item = '0;
		idle_pct = 10;
		stall_pct = 10;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		msg.push_back(8'hf8);
		send_msg();
		msg.push_back(8'h00);
		send_msg();
		msg = '{8'hf7, 8'h12, 8'hff};
		send_msg();
		build_stateful(2'd1, -1, 0);
		send_msg();
		build_stateful(2'd3, 0, 1);
		msg[1] = 8'h80;
		send_msg();
		build_stateful(2'd2, 127, 3);
		send_msg();
		build_stateless(-1, 12'd1, 4'd1, 0);
		send_msg();
		build_stateless(0, 12'h0ff, 4'hf, 2);
		send_msg();
		build_stateless(-1, 12'd5, 4'd0, 3);
		send_msg();
		build_nack(-1, 4'd1, 0);
		send_msg();
		build_nack(-1, 4'd1, 0);
		cut_to(25);
		send_msg();
		build_nack(3, 4'd2, 4);
		send_msg();
		build_nack(-1, 4'd0, 0);
		cut_to(10);
		send_msg();
		build_stateful(2'd1, 5, 0);
		cut_to(4);
		send_msg();
		build_stateful(2'd3, -1, 0);
		cut_to(8);
		send_msg();
		build_stateless(-1, 12'd9, 4'd3, 0);
		cut_to(2);
		send_msg();
		build_stateless(-1, 12'd9, 4'd3, 0);
		cut_to(7);
		send_msg();
		// long NACK: details run well past the fixed fields
		build_nack(-1, 4'd1, 40);
		send_msg();

		// drain before the random part
		byte_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);

		while (bytes_sent < 1150) begin
			if (bytes_sent > 1000) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				pick = $urandom_range(0, 2);
				idle_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 35;
				pick = $urandom_range(0, 2);
				stall_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 35;
			end
			fb = $urandom_range(0, 3);
			fb = (fb < 2) ? -1 : (fb == 2) ? 0 : $urandom_range(1, 6);
			pick = $urandom_range(0, 99);
			if (pick >= 87 && pick < 95) begin
				case ($urandom_range(0, 2))
					0: build_stateful(2'($urandom_range(1, 3)), fb, $urandom_range(0, 8));
					1: build_stateless(fb, 12'($urandom_range(1, 40)),
						4'($urandom_range(1, 15)), $urandom_range(0, 8));
					default: build_nack(fb, 4'd1, $urandom_range(0, 6));
				endcase
				cut_to($urandom_range(1, msg.size() - 1));
			end else if (pick < 25) begin
				build_stateful(2'($urandom_range(1, 3)), fb, $urandom_range(0, 8));
			end else if (pick < 50) begin
				build_stateless(fb, ($urandom_range(0, 9) == 0) ? 12'($urandom_range(41, 300)) :
					12'($urandom_range(1, 40)), 4'($urandom_range(1, 15)), $urandom_range(0, 8));
			end else if (pick < 72) begin
				build_nack(fb, ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'd1,
					$urandom_range(0, 6));
			end else if (pick < 80) begin
				msg.push_back(8'($urandom_range(0, 247)));
				put_rand($urandom_range(0, 6));
			end else if (pick < 87) begin
				build_stateless(fb, 12'($urandom_range(1, 40)), 4'd0, $urandom_range(0, 4));
			end else begin
				put_rand($urandom_range(1, 10));
			end
			send_msg();
		end

		byte_valid <= 1'b0;
		for (w = 0; w < 500 && outstanding != 0; w++)
			@(negedge clk);
		repeat (6) @(negedge clk);

		$display("covered %0d bytes in %0d messages: %0d parsed clean, %0d rejected or cut short",
			bytes_sent, msgs_ok + msgs_bad, msgs_ok, msgs_bad);
		if (outstanding != 0)
			$display("%0d results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("sigcomp_message_header_parser_test OK");
		end else begin
			$display("sigcomp_message_header_parser_test NOT OK");
		end
		$finish;
	end

endmodule
